### hw/rtl/aeske_pkg.sv
package aeske_pkg;

   localparam int KeyWordWidth   = 64;
   localparam int RoundKeyWidth  = 128;
   localparam int MaxRounds      = 14;
   localparam int RkDepth        = MaxRounds + 1;
   localparam int RkAddrWidth    = $clog2(RkDepth);
   localparam int SchedDepth     = 8;

   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;
   localparam logic [1:0] MODE_256 = 2'd2;

   localparam logic CSR_KEY_SIZE_MODE = 1'b0;
   localparam logic CSR_EMIT_DECRYPT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_READ,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       en;
      logic       sub_rot;
      logic [7:0] rcon;
   } word_op_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] r;
      for (int k = 0; k < 4; k++) begin
         a[k]  = w[8*k +: 8];
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m9[k] = x8[k] ^ a[k];
         mb[k] = x8[k] ^ x2[k] ^ a[k];
         md[k] = x8[k] ^ x4[k] ^ a[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      r[7:0]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      r[15:8]  = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      r[23:16] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      r[31:24] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      return r;
   endfunction

endpackage

### hw/rtl/aeske_ram.sv
module aeske_ram #(
   parameter int Width = 128,
   parameter int Depth = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/aeske_word_unit.sv
// one schedule word per cycle: optional rotate, s-box and rcon on the previous word
module aeske_word_unit (
   input  aeske_pkg::word_op_type op,
   input  logic [31:0]            prev_word,
   input  logic [31:0]            far_word,
   output logic [31:0]            new_word
);
   logic [31:0] sel;
   logic [31:0] subbed;

   always_comb begin
      sel = op.sub_rot ? {prev_word[7:0], prev_word[31:8]} : prev_word;
      for (int k = 0; k < 4; k++) begin
         subbed[8*k +: 8] = aeske_pkg::sbox(sel[8*k +: 8]);
      end
      if (op.en) begin
         new_word = far_word ^ subbed ^ {24'd0, op.rcon};
      end else begin
         new_word = far_word ^ prev_word;
      end
   end
endmodule

### hw/rtl/aes_key_expansion_core.sv
// channel | direction | ports                                    | accepted when
// request | in        | req_key_word, req_word_index, req_last_word | req_valid && !req_stall
// response| out       | rsp_round_key_half .. rsp_last_result     | rsp_valid && !rsp_stall
// config  | in        | csr_write, csr_index, csr_data            | csr_write
// a request word is stored when taken; a last request runs the schedule, one word per
// schedule cycle (first Nk words from the key store, the rest through the shared word
// unit), then each round key is read from the round-key ram (ST_READ, ST_WAIT) and sent
// as two halves, lower first; encryption keys, then reversed decryption keys if enabled.
// reset is synchronous; the key store and round keys are not cleared.
// a stalled response holds until taken; no request is taken until the last half is sent.
module aes_key_expansion_core #(
   parameter int RkDepth = aeske_pkg::RkDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_word,
   input  logic [1:0]  req_word_index,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_round_key_half,
   output logic [3:0]  rsp_round_number,
   output logic        rsp_upper_half,
   output logic        rsp_decrypt_schedule,
   output logic        rsp_last_result,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);
   localparam int AddrW = $clog2(RkDepth);

   aeske_pkg::state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic        emit_dec_ff;
   logic [63:0] key_ff [4];
   logic [31:0] sched_ff [8];
   logic [7:0]  rcon_ff, rcon_in;
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  phase_ff, phase_in;   // i mod nk
   logic [127:0] acc_ff, acc_in;
   logic [3:0]  nr, nk_m1;
   logic [5:0]  total_m1;
   logic [3:0]  rnd_ff, rnd_in;
   logic        dec_ff, dec_in;
   logic        half_ff, half_in;
   logic [127:0] rk_rd;
   logic [127:0] out_key_ff;
   logic        ram_we;
   logic [AddrW-1:0] rd_addr;
   logic [31:0] new_word, prev_word, far_word, key_src;
   aeske_pkg::word_op_type op;
   logic        req_take;
   logic        rsp_take;
   logic        last_half;

   function automatic logic [127:0] rk_key(input logic [127:0] k, input logic [3:0] r,
                                           input logic d, input logic [3:0] n);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[32*c +: 32] = aeske_pkg::inv_mix_word(k[32*c +: 32]);
      end
      return (d && r != 4'd0 && r != n) ? o : k;
   endfunction

   always_comb begin
      case (mode_ff)
         aeske_pkg::MODE_192: begin nr = 4'd12; nk_m1 = 4'd5; end
         aeske_pkg::MODE_256: begin nr = 4'd14; nk_m1 = 4'd7; end
         default:             begin nr = 4'd10; nk_m1 = 4'd3; end
      endcase
      total_m1 = {nr, 2'b11};
   end

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != aeske_pkg::ST_IDLE);
   assign last_half = half_ff && (rnd_ff == nr) && (dec_ff || !emit_dec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= aeske_pkg::MODE_128;
         emit_dec_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            aeske_pkg::CSR_KEY_SIZE_MODE: mode_ff     <= csr_data;
            aeske_pkg::CSR_EMIT_DECRYPT:  emit_dec_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // schedule word path
   always_comb begin
      key_src   = key_ff[idx_ff[2:1]][32*idx_ff[0] +: 32];
      prev_word = sched_ff[(phase_ff == 3'd0) ? nk_m1[2:0] : phase_ff - 3'd1];
      far_word  = sched_ff[phase_ff];
      op.en      = (phase_ff == 3'd0) || (nk_m1 == 4'd7 && phase_ff == 3'd4);
      op.sub_rot = (phase_ff == 3'd0);
      op.rcon    = (phase_ff == 3'd0) ? rcon_ff : 8'h00;
   end

   aeske_word_unit u_word (
      .op        (op),
      .prev_word (prev_word),
      .far_word  (far_word),
      .new_word  (new_word)
   );

   logic [31:0] word_w;
   assign word_w = (idx_ff <= {2'b00, nk_m1}) ? key_src : new_word;

   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff[req_word_index] <= req_key_word;
      end
      if (state_ff == aeske_pkg::ST_EXPAND) begin
         sched_ff[phase_ff] <= word_w;
      end
      acc_ff     <= acc_in;
      out_key_ff <= (state_ff == aeske_pkg::ST_WAIT) ? rk_key(rk_rd, rnd_ff, dec_ff, nr)
                                                     : out_key_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      acc_in[32*idx_ff[1:0] +: 32] = word_w;
      ram_we = (state_ff == aeske_pkg::ST_EXPAND) && (idx_ff[1:0] == 2'd3);
      rd_addr = dec_ff ? AddrW'(nr - rnd_ff) : AddrW'(rnd_ff);
   end

   aeske_ram #(.Width(128), .Depth(RkDepth)) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AddrW'(idx_ff[5:2])),
      .wr_data (acc_in),
      .rd_addr (rd_addr),
      .rd_data (rk_rd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aeske_pkg::ST_IDLE:   if (req_take && req_last_word) state_in = aeske_pkg::ST_EXPAND;
         aeske_pkg::ST_EXPAND: if (idx_ff == total_m1) state_in = aeske_pkg::ST_READ;
         aeske_pkg::ST_READ:   state_in = aeske_pkg::ST_WAIT;
         aeske_pkg::ST_WAIT:   state_in = aeske_pkg::ST_EMIT;
         aeske_pkg::ST_EMIT: begin
            if (rsp_take && half_ff) begin
               state_in = last_half ? aeske_pkg::ST_IDLE : aeske_pkg::ST_READ;
            end
         end
         default: state_in = aeske_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      phase_in = phase_ff;
      rcon_in  = rcon_ff;
      rnd_in   = rnd_ff;
      dec_in   = dec_ff;
      half_in  = half_ff;
      case (state_ff)
         aeske_pkg::ST_IDLE: begin
            idx_in = '0; phase_in = '0; rcon_in = 8'h01;
            rnd_in = '0; dec_in = 1'b0; half_in = 1'b0;
         end
         aeske_pkg::ST_EXPAND: begin
            idx_in   = idx_ff + 6'd1;
            phase_in = ({1'b0, phase_ff} == nk_m1) ? 3'd0 : phase_ff + 3'd1;
            if (phase_ff == 3'd0 && idx_ff > {2'b00, nk_m1}) rcon_in = aeske_pkg::xtime(rcon_ff);
         end
         aeske_pkg::ST_EMIT: begin
            if (rsp_take) begin
               half_in = !half_ff;
               if (half_ff) begin
                  if (rnd_ff == nr) begin
                     rnd_in = '0; dec_in = 1'b1;
                  end else begin
                     rnd_in = rnd_ff + 4'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aeske_pkg::ST_IDLE;
         idx_ff <= '0; phase_ff <= '0; rcon_ff <= 8'h01;
         rnd_ff <= '0; dec_ff <= 1'b0; half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in; phase_ff <= phase_in; rcon_ff <= rcon_in;
         rnd_ff <= rnd_in; dec_ff <= dec_in; half_ff <= half_in;
      end
   end

   always_comb begin
      rsp_valid            = (state_ff == aeske_pkg::ST_EMIT);
      rsp_round_key_half   = half_ff ? out_key_ff[127:64] : out_key_ff[63:0];
      rsp_round_number     = rnd_ff;
      rsp_upper_half       = half_ff;
      rsp_decrypt_schedule = dec_ff;
      rsp_last_result      = last_half;
   end

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != aeske_pkg::ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == aeske_pkg::ST_EMIT)
      else $error("response outside emit");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_round_number <= nr)
      else $error("round number out of range");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_result |=> state_ff == aeske_pkg::ST_IDLE)
      else $error("did not return to idle");
endmodule
